### design/scf_pkg.sv
// Package for the sum-checked frame parser: field widths, reset constants
// and the frame hand-over type passed from the parser to the emitter.
// No dependencies.
`default_nettype none

package scf_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int IDX_W  = 5;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;

    // A frame whose checksum matched, handed to the emitter for draining.
    typedef struct packed {
        logic              start;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] command;
    } scf_frame_t;

endpackage : scf_pkg

`default_nettype wire

### design/sum_checked_frame_parser.sv
// Top level of the sum-checked frame parser: parser, payload buffer RAM
// and emitter. Depends on scf_pkg, scf_ram, scf_parser and scf_emitter.
//
//   Channel   Handshake               Payload
//   input     in_valid / in_stall     rx_byte
//   output    out_valid / out_stall   is_payload, data_byte, frame_length,
//                                     byte_index, last_of_frame
//   config    cfg_we                  cfg_wdata (header value)
//
// One received byte is taken per cycle while no frame is being drained.
// After a checksum match the input is stalled while the frame drains: the
// command transaction is loaded first, then one payload transaction per
// cycle, paced by the single read port of the payload RAM and by out_stall.
// Reset is asynchronous and active low; the payload RAM is not cleared, as
// only entries written in the current frame are ever read.
`default_nettype none

module sum_checked_frame_parser #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [scf_pkg::BYTE_W-1:0] cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [scf_pkg::BYTE_W-1:0] rx_byte,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            is_payload,
    output logic      [scf_pkg::BYTE_W-1:0] data_byte,
    output logic      [scf_pkg::LEN_W-1:0]  frame_length,
    output logic      [scf_pkg::IDX_W-1:0]  byte_index,
    output logic                            last_of_frame
);

    import scf_pkg::*;

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    scf_frame_t        frame;
    logic              busy;
    logic              byte_valid;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    assign in_stall   = busy;
    assign byte_valid = in_valid && !busy;

    scf_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .frame      (frame)
    );

    scf_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (ADDR_W)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    scf_emitter #(
        .ADDR_W (ADDR_W)
    ) u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame         (frame),
        .busy          (busy),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .is_payload    (is_payload),
        .data_byte     (data_byte),
        .frame_length  (frame_length),
        .byte_index    (byte_index),
        .last_of_frame (last_of_frame)
    );

endmodule : sum_checked_frame_parser

`default_nettype wire

### design/scf_ram.sv
// Generic simple dual-port RAM: one synchronous write port and one read
// port with registered read data. No dependencies.
`default_nettype none

module scf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : scf_ram

`default_nettype wire

### design/scf_parser.sv
// Byte-level frame parser: header search, length check, running checksum
// and payload writes into the buffer RAM. Depends on scf_pkg.
`default_nettype none

module scf_parser #(
    parameter int MAX_PAYLOAD = 32,
    parameter int ADDR_W      = 5
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [scf_pkg::BYTE_W-1:0] cfg_wdata,
    input  wire logic                       byte_valid,
    input  wire logic [scf_pkg::BYTE_W-1:0] rx_byte,
    output logic                            wr_en,
    output logic      [ADDR_W-1:0]          wr_addr,
    output logic      [scf_pkg::BYTE_W-1:0] wr_data,
    output scf_pkg::scf_frame_t             frame
);

    import scf_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_COMMAND,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);
    localparam logic [LEN_W-1:0]  MAX_CNT = LEN_W'(MAX_PAYLOAD);

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] header_reg, header_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [BYTE_W-1:0] command_reg, command_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  count_inc;

    assign count_inc = count_reg + LEN_W'(1);
    assign wr_addr   = count_reg[ADDR_W-1:0];
    assign wr_data   = rx_byte;

    always_comb
    begin
        phase_next    = phase_reg;
        header_next   = cfg_we ? cfg_wdata : header_reg;
        length_next   = length_reg;
        command_next  = command_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        wr_en         = 1'b0;
        frame.start   = 1'b0;
        frame.length  = length_reg;
        frame.command = command_reg;
        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (rx_byte == header_reg)
                    begin
                        phase_next = PH_LENGTH;
                    end
                end
                PH_LENGTH:
                begin
                    // An oversized length drops straight back to header search.
                    if (rx_byte <= MAX_LEN)
                    begin
                        length_next = rx_byte[LEN_W-1:0];
                        sum_next    = rx_byte;
                        phase_next  = PH_COMMAND;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_COMMAND:
                begin
                    command_next = rx_byte;
                    sum_next     = sum_reg + rx_byte;
                    count_next   = '0;
                    phase_next   = (length_reg != '0) ? PH_PAYLOAD : PH_CHECK;
                end
                PH_PAYLOAD:
                begin
                    wr_en      = (count_reg < MAX_CNT);
                    sum_next   = sum_reg + rx_byte;
                    count_next = count_inc;
                    if (count_inc >= length_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    frame.start = (rx_byte == sum_reg);
                    phase_next  = PH_HEADER;
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            header_reg  <= HEADER_RESET;
            length_reg  <= '0;
            command_reg <= '0;
            sum_reg     <= '0;
            count_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            header_reg  <= header_next;
            length_reg  <= length_next;
            command_reg <= command_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
        end
    end

endmodule : scf_parser

`default_nettype wire

### design/scf_emitter.sv
// Frame emitter: reads the buffered payload back from the RAM and drives
// the output register, command first. Depends on scf_pkg.
`default_nettype none

module scf_emitter #(
    parameter int ADDR_W = 5
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire scf_pkg::scf_frame_t        frame,
    output logic                            busy,
    output logic                            rd_en,
    output logic      [ADDR_W-1:0]          rd_addr,
    input  wire logic [scf_pkg::BYTE_W-1:0] rd_data,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            is_payload,
    output logic      [scf_pkg::BYTE_W-1:0] data_byte,
    output logic      [scf_pkg::LEN_W-1:0]  frame_length,
    output logic      [scf_pkg::IDX_W-1:0]  byte_index,
    output logic                            last_of_frame
);

    import scf_pkg::*;

    typedef enum logic [1:0] {
        E_IDLE,
        E_CMD,
        E_FETCH
    } emit_state_t;

    emit_state_t       state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [LEN_W-1:0]  idx_inc;
    logic              can_load;

    logic              valid_reg, valid_next;
    logic              pay_reg, pay_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic [LEN_W-1:0]  flen_reg, flen_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic              last_reg, last_next;

    assign idx_inc  = idx_reg + LEN_W'(1);
    assign can_load = !valid_reg || !out_stall;
    assign busy     = (state_reg != E_IDLE);

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        valid_next = valid_reg && out_stall;
        pay_next   = pay_reg;
        data_next  = data_reg;
        flen_next  = flen_reg;
        index_next = index_reg;
        last_next  = last_reg;
        unique case (state_reg)
            E_IDLE:
            begin
                if (frame.start)
                begin
                    len_next   = frame.length;
                    cmd_next   = frame.command;
                    state_next = E_CMD;
                end
            end
            E_CMD:
            begin
                if (can_load)
                begin
                    valid_next = 1'b1;
                    pay_next   = 1'b0;
                    data_next  = cmd_reg;
                    flen_next  = len_reg;
                    index_next = '0;
                    last_next  = (len_reg == '0);
                    if (len_reg != '0)
                    begin
                        rd_en      = 1'b1;
                        idx_next   = '0;
                        state_next = E_FETCH;
                    end
                    else
                    begin
                        state_next = E_IDLE;
                    end
                end
            end
            E_FETCH:
            begin
                // The RAM output holds the entry at idx_reg until the next read.
                if (can_load)
                begin
                    valid_next = 1'b1;
                    pay_next   = 1'b1;
                    data_next  = rd_data;
                    flen_next  = len_reg;
                    index_next = idx_reg[IDX_W-1:0];
                    last_next  = (idx_inc == len_reg);
                    if (idx_inc == len_reg)
                    begin
                        state_next = E_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc[ADDR_W-1:0];
                        idx_next = idx_inc;
                    end
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            len_reg   <= '0;
            cmd_reg   <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
            pay_reg   <= 1'b0;
            data_reg  <= '0;
            flen_reg  <= '0;
            index_reg <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            cmd_reg   <= cmd_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            pay_reg   <= pay_next;
            data_reg  <= data_next;
            flen_reg  <= flen_next;
            index_reg <= index_next;
            last_reg  <= last_next;
        end
    end

    // The frame length travels with each transaction, so a new frame that
    // arrives while the last one is still stalled cannot disturb it.
    assign out_valid     = valid_reg;
    assign is_payload    = pay_reg;
    assign data_byte     = data_reg;
    assign frame_length  = flen_reg;
    assign byte_index    = index_reg;
    assign last_of_frame = last_reg;

endmodule : scf_emitter

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for sum_checked_frame_parser: directed frames, then random frames
// under several idle and stall mixes, checked against a local parser or fixed script rows.
// Depends on scf_pkg and the sum_checked_frame_parser RTL.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import scf_pkg::*;

    localparam int PAYLOAD_MAX   = 32;
    localparam int RANDOM_BUDGET = 72;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam int SEND_IDLE  [4] = '{0, 81, 0, 12};
    localparam int RECV_STALL [4] = '{0, 0, 81, 12};

    typedef enum logic [2:0] {
        SEEK_HEADER,
        TAKE_LENGTH,
        TAKE_COMMAND,
        TAKE_PAYLOAD,
        TAKE_CHECKSUM
    } parse_phase_e;

    typedef struct packed {
        logic              is_pay;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } frame_item_t;

    // One byte of the directed script; where fixed is set, the expected outcome is
    // written out here (none, or the single item given) instead of taken from the parser.
    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              fixed;
        logic              fixed_one;
        frame_item_t       item;
    } script_row_t;

    localparam frame_item_t NO_ITEM = '0;

    localparam script_row_t SCRIPT [20] = '{
        '{8'h00, 1'b1, 1'b0, NO_ITEM},   // noise while hunting for the header
        '{8'hFF, 1'b1, 1'b0, NO_ITEM},
        '{8'hAA, 1'b1, 1'b0, NO_ITEM},
        '{8'h21, 1'b1, 1'b0, NO_ITEM},   // length one above the bound
        '{8'hAA, 1'b1, 1'b0, NO_ITEM},
        '{8'hAA, 1'b1, 1'b0, NO_ITEM},   // oversized length equal to the header value
        '{8'hAA, 1'b1, 1'b0, NO_ITEM},
        '{8'h00, 1'b1, 1'b0, NO_ITEM},   // zero-length frame
        '{8'hFF, 1'b1, 1'b0, NO_ITEM},
        '{8'hFF, 1'b1, 1'b1, '{1'b0, 8'hFF, 6'd0, 5'd0, 1'b1}},
        '{8'hAA, 1'b1, 1'b0, NO_ITEM},   // zero-length frame with a bad checksum
        '{8'h00, 1'b1, 1'b0, NO_ITEM},
        '{8'h5A, 1'b1, 1'b0, NO_ITEM},
        '{8'h00, 1'b1, 1'b0, NO_ITEM},
        '{8'hAA, 1'b1, 1'b0, NO_ITEM},   // two payload bytes, checksum wraps
        '{8'h02, 1'b1, 1'b0, NO_ITEM},
        '{8'h00, 1'b1, 1'b0, NO_ITEM},
        '{8'h00, 1'b1, 1'b0, NO_ITEM},
        '{8'hFF, 1'b1, 1'b0, NO_ITEM},
        '{8'h01, 1'b0, 1'b0, NO_ITEM}
    };

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [BYTE_W-1:0] cfg_wdata = '0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] rx_byte   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              is_payload;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  frame_length;
    logic [IDX_W-1:0]  byte_index;
    logic              last_of_frame;

    sum_checked_frame_parser #(
        .MAX_PAYLOAD(PAYLOAD_MAX)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_payload   (is_payload),
        .data_byte    (data_byte),
        .frame_length (frame_length),
        .byte_index   (byte_index),
        .last_of_frame(last_of_frame)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Local copy of the parser state.
    parse_phase_e      phase      = SEEK_HEADER;
    logic [BYTE_W-1:0] header_cfg = HEADER_RESET;
    logic [LEN_W-1:0]  frm_len    = '0;
    logic [BYTE_W-1:0] frm_cmd    = '0;
    logic [BYTE_W-1:0] frm_sum    = '0;
    logic [LEN_W-1:0]  pay_count  = '0;
    logic [BYTE_W-1:0] pay_buf [PAYLOAD_MAX];

    frame_item_t       decoded_items [$];
    frame_item_t       awaited_items [$];
    logic [BYTE_W-1:0] frame_bytes [$];

    // Side information for the byte currently offered, read when it is accepted.
    logic              cur_fixed     = 1'b0;
    logic              cur_fixed_one = 1'b0;
    frame_item_t       cur_item      = '0;

    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int failures      = 0;
    int cycle_count   = 0;

    frame_item_t seen;
    assign seen = {is_payload, data_byte, frame_length, byte_index, last_of_frame};

    function automatic void parse_byte(input logic [BYTE_W-1:0] b);
        decoded_items.delete();
        case (phase)
            SEEK_HEADER:
            begin
                if (b == header_cfg)
                    phase = TAKE_LENGTH;
            end
            TAKE_LENGTH:
            begin
                if (b <= PAYLOAD_MAX)
                begin
                    frm_len = b[LEN_W-1:0];
                    frm_sum = b;
                    phase   = TAKE_COMMAND;
                end
                else
                    phase = SEEK_HEADER;
            end
            TAKE_COMMAND:
            begin
                frm_cmd   = b;
                frm_sum   = frm_sum + b;
                pay_count = '0;
                phase     = (frm_len != 0) ? TAKE_PAYLOAD : TAKE_CHECKSUM;
            end
            TAKE_PAYLOAD:
            begin
                if (pay_count < PAYLOAD_MAX)
                    pay_buf[pay_count] = b;
                frm_sum   = frm_sum + b;
                pay_count = pay_count + 1'b1;
                if (pay_count >= frm_len)
                    phase = TAKE_CHECKSUM;
            end
            TAKE_CHECKSUM:
            begin
                if (b == frm_sum)
                begin
                    decoded_items.push_back('{1'b0, frm_cmd, frm_len, '0, frm_len == 0});
                    for (int k = 0; k < int'(frm_len) && k < PAYLOAD_MAX; k++)
                        decoded_items.push_back('{1'b1, pay_buf[k], frm_len,
                                                   IDX_W'(k), k + 1 == int'(frm_len)});
                end
                phase = SEEK_HEADER;
            end
            default:
                phase = SEEK_HEADER;
        endcase
    endfunction

    // Appends one random frame, or a broken one, or a little line noise.
    function automatic void add_frame(input bit only_good, input int fixed_len);
        int                pick;
        int                len;
        int                keep;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        pick = only_good ? 0 : $urandom_range(99);
        if (fixed_len >= 0)
            len = fixed_len;
        else
        begin
            keep = $urandom_range(99);
            if (keep < 6)
                len = PAYLOAD_MAX;
            else if (keep < 10)
                len = PAYLOAD_MAX - 1;
            else if (keep < 22)
                len = 0;
            else
                len = $urandom_range(1, 8);
        end
        if (pick >= 90)
        begin
            repeat ($urandom_range(1, 4))
            begin
                do
                    b = BYTE_W'($urandom);
                while (b == header_cfg);
                frame_bytes.push_back(b);
            end
        end
        else if (pick >= 82)
        begin
            frame_bytes.push_back(header_cfg);
            frame_bytes.push_back(BYTE_W'($urandom_range(PAYLOAD_MAX + 1, 255)));
        end
        else
        begin
            // A truncated frame stops part-way through its payload.
            if (pick >= 74 && len < 2)
                len = 2;
            keep = (pick >= 74) ? $urandom_range(0, len - 1) : len;
            cmd  = BYTE_W'($urandom);
            sum  = BYTE_W'(len) + cmd;
            frame_bytes.push_back(header_cfg);
            frame_bytes.push_back(BYTE_W'(len));
            frame_bytes.push_back(cmd);
            for (int i = 0; i < keep; i++)
            begin
                b   = BYTE_W'($urandom);
                sum = sum + b;
                frame_bytes.push_back(b);
            end
            if (pick < 74)
            begin
                if (pick >= 64)
                    sum = sum ^ BYTE_W'($urandom_range(1, 255));
                frame_bytes.push_back(sum);
            end
        end
    endfunction

    task automatic compare_field(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            failures++;
        end
    endtask

    // Checks the result transaction first, then predicts from the accepted input byte.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_items.size() == 0)
                begin
                    $display("%0t ns: unexpected result, actual %h", $time, seen);
                    failures++;
                end
                else
                begin
                    compare_field("is_payload", 8'(awaited_items[0].is_pay), 8'(seen.is_pay));
                    compare_field("data_byte", awaited_items[0].data, seen.data);
                    compare_field("frame_length", 8'(awaited_items[0].len), 8'(seen.len));
                    compare_field("byte_index", 8'(awaited_items[0].idx), 8'(seen.idx));
                    compare_field("last_of_frame", 8'(awaited_items[0].last), 8'(seen.last));
                    void'(awaited_items.pop_front());
                end
            end
            if (in_valid && !in_stall)
            begin
                parse_byte(rx_byte);
                if (cur_fixed)
                begin
                    if (cur_fixed_one)
                        awaited_items.push_back(cur_item);
                end
                else
                    foreach (decoded_items[i])
                        awaited_items.push_back(decoded_items[i]);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t ns: timed out with %0d results awaited", $time, awaited_items.size());
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fixed,
                             input logic fixed_one, input frame_item_t item);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        rx_byte       <= b;
        cur_fixed     = fixed;
        cur_fixed_one = fixed_one;
        cur_item      = item;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_frames();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], 1'b0, 1'b0, NO_ITEM);
        frame_bytes.delete();
    endtask

    // Drops valid after the last transaction and waits for every result to come out.
    task automatic drain_results(input int settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_items.size() != 0)
            @(posedge clk);
        repeat (settle)
            @(posedge clk);
    endtask

    task automatic write_header(input logic [BYTE_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we     <= 1'b0;
        header_cfg = value;
    endtask

    initial
    begin : stimulus
        int                sent;
        logic [BYTE_W-1:0] hdr;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (SCRIPT[i])
            send_byte(SCRIPT[i].rx, SCRIPT[i].fixed, SCRIPT[i].fixed_one, SCRIPT[i].item);
        drain_results(8);

        for (int p = 0; p < 4; p++)
        begin
            if (p > 0)
            begin
                hdr = (p == 1) ? 8'h00 : (p == 2) ? 8'hFF : BYTE_W'($urandom);
                write_header(hdr);
            end
            idle_pct  = SEND_IDLE[p];
            stall_pct = RECV_STALL[p];
            sent = 0;
            // The first random frame of the run carries the largest payload.
            if (p == 0)
                add_frame(1'b1, PAYLOAD_MAX);
            while (sent < RANDOM_BUDGET)
            begin
                if (frame_bytes.size() == 0)
                    add_frame(1'b0, -1);
                sent += frame_bytes.size();
                send_frames();
            end
            drain_results(8);
        end

        // Long receiver hold-off while the sender keeps offering good frames.
        write_header(HEADER_RESET);
        idle_pct  = 0;
        stall_pct = 0;
        hold_requests++;
        repeat (3)
            add_frame(1'b1, $urandom_range(16, 24));
        send_frames();
        drain_results(40);

        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
design/scf_pkg.sv
design/scf_ram.sv
design/scf_parser.sv
design/scf_emitter.sv
design/sum_checked_frame_parser.sv
sim/testbench.sv
